@@ src/bccm_pkg.sv @@
// Package for the bounded coin change (most coins) block.
// Types, state encoding, control structs and the denomination table.
// No dependencies.
`default_nettype none

package bccm_pkg;

	localparam int NUM_DENOM_ALL = 8;
	localparam int NUM_LEVELS    = 6;
	localparam int LVL_W         = 3;
	localparam int DENOM_W       = 8;
	localparam int PRICE_W       = 16;
	localparam int COIN_W        = 18;
	localparam int REM_W         = 18;
	localparam int BEST_W        = 11;

	typedef logic [LVL_W-1:0]          lvl_t;
	typedef logic [COIN_W-1:0]         coin_t;
	typedef logic signed [REM_W-1:0]   rem_t;

	localparam logic [BEST_W-1:0] BEST_MAX   = 11'h7ff;
	localparam lvl_t              IDX_LAST   = 3'd6;
	localparam lvl_t              LVL_LAST   = 3'd5;
	localparam lvl_t              LVL_NUM    = 3'd6;
	localparam lvl_t              DENOM_LAST = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_EVAL,
		ST_ADV,
		ST_BOT1,
		ST_BOT2,
		ST_DONE
	} state_t;

	// node verdict: brk closes the level, skip moves to the next count
	typedef struct packed {
		logic brk;
		logic skip;
	} node_stat_t;

	typedef struct packed {
		logic load;
		logic init_acc;
		logic push;
		logic adv;
		logic pop;
		logic bot1;
		logic bot2;
		logic done;
		lvl_t depth;
		lvl_t idx;
	} ctrl_t;

	function automatic logic [DENOM_W-1:0] denom_value(input lvl_t idx);
		logic [DENOM_W-1:0] v;
		case (idx)
			3'd0: v = 8'd1;
			3'd1: v = 8'd2;
			3'd2: v = 8'd5;
			3'd3: v = 8'd10;
			3'd4: v = 8'd20;
			3'd5: v = 8'd50;
			3'd6: v = 8'd100;
			default: v = 8'd200;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ src/bccm_ctrl.sv @@
// Search sequencer: table setup, depth-first walk over levels, result strobe.
// Depends on bccm_pkg.
`default_nettype none

module bccm_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire bccm_pkg::node_stat_t stat,
	output logic                 busy,
	output bccm_pkg::ctrl_t      ctl
);

	bccm_pkg::state_t state_q, state_d;
	bccm_pkg::lvl_t   depth_q;
	bccm_pkg::lvl_t   idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bccm_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bccm_pkg::ST_INIT;
				end
			end
			bccm_pkg::ST_INIT: begin
				if (idx_q == bccm_pkg::IDX_LAST) begin
					state_d = bccm_pkg::ST_EVAL;
				end
			end
			bccm_pkg::ST_EVAL: begin
				if (stat.brk) begin
					state_d = (depth_q == '0) ? bccm_pkg::ST_DONE : bccm_pkg::ST_ADV;
				end else if (!stat.skip && depth_q == bccm_pkg::LVL_LAST) begin
					state_d = bccm_pkg::ST_BOT1;
				end
			end
			bccm_pkg::ST_ADV:  state_d = bccm_pkg::ST_EVAL;
			bccm_pkg::ST_BOT1: state_d = bccm_pkg::ST_BOT2;
			bccm_pkg::ST_BOT2: state_d = bccm_pkg::ST_ADV;
			bccm_pkg::ST_DONE: state_d = bccm_pkg::ST_IDLE;
			default:           state_d = bccm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		ctl.depth = depth_q;
		ctl.idx   = idx_q;
		case (state_q)
			bccm_pkg::ST_IDLE: ctl.load = start;
			bccm_pkg::ST_INIT: ctl.init_acc = 1'b1;
			bccm_pkg::ST_EVAL: begin
				ctl.pop  = stat.brk;
				ctl.adv  = !stat.brk && stat.skip;
				ctl.push = !stat.brk && !stat.skip && (depth_q != bccm_pkg::LVL_LAST);
			end
			bccm_pkg::ST_ADV:  ctl.adv  = 1'b1;
			bccm_pkg::ST_BOT1: ctl.bot1 = 1'b1;
			bccm_pkg::ST_BOT2: ctl.bot2 = 1'b1;
			bccm_pkg::ST_DONE: ctl.done = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != bccm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bccm_pkg::ST_IDLE;
			depth_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				depth_q <= '0;
				idx_q   <= '0;
			end else begin
				if (ctl.push) begin
					depth_q <= depth_q + bccm_pkg::lvl_t'(1);
				end else if (ctl.pop && depth_q != '0) begin
					depth_q <= depth_q - bccm_pkg::lvl_t'(1);
				end
				if (ctl.init_acc) begin
					idx_q <= idx_q + bccm_pkg::lvl_t'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ src/bccm_node.sv @@
// Node evaluation unit: range, reachability and coin-bound tests for one count.
// Depends on bccm_pkg.
`default_nettype none

module bccm_node #(
	parameter int COUNT_BITS = 8
) (
	input  wire [COUNT_BITS:0]           k,
	input  wire bccm_pkg::coin_t         ck,
	input  wire bccm_pkg::rem_t          rp,
	input  wire [COUNT_BITS-1:0]         cnt,
	input  wire [COUNT_BITS+8:0]         cap,
	input  wire [COUNT_BITS+2:0]         cntb,
	input  wire bccm_pkg::coin_t         best,
	input  wire                          found,
	output bccm_pkg::node_stat_t         stat
);

	localparam int CAP_W = COUNT_BITS + 9;
	localparam int EXT_W = ((CAP_W > bccm_pkg::COIN_W) ? CAP_W : bccm_pkg::COIN_W) + 1;

	logic [EXT_W-1:0] rp_e, cap_e, cntb_e, ck_e, best_e, lim_e, ub_all, ub_cnt;
	logic             rp_neg, k_over;

	always_comb begin
		rp_neg = rp[bccm_pkg::REM_W-1];
		rp_e   = EXT_W'(rp[bccm_pkg::REM_W-2:0]);
		cap_e  = EXT_W'(cap);
		cntb_e = EXT_W'(cntb);
		ck_e   = EXT_W'(ck);
		best_e = EXT_W'(best);
		lim_e  = (cntb_e < rp_e) ? cntb_e : rp_e;
		ub_all = ck_e + rp_e;
		ub_cnt = ck_e + lim_e;
		k_over = (k > {1'b0, cnt});
		stat.brk  = k_over || rp_neg || (found && ub_all <= best_e);
		stat.skip = (rp_e > cap_e) || (found && ub_cnt <= best_e);
	end

endmodule

`default_nettype wire

@@ src/bccm_bottom.sv @@
// Closed-form finish for the 2 and 1 denominations, registered on bot1 and judged on bot2.
// Depends on bccm_pkg.
`default_nettype none

module bccm_bottom #(
	parameter int COUNT_BITS = 8
) (
	input  wire                                clk,
	input  wire bccm_pkg::ctrl_t               ctl,
	input  wire [bccm_pkg::REM_W-2:0]          rem,
	input  wire bccm_pkg::coin_t               base,
	input  wire [COUNT_BITS-1:0]               c1,
	input  wire [COUNT_BITS-1:0]               c2,
	input  wire bccm_pkg::coin_t               best,
	input  wire                                found,
	output logic                               upd,
	output bccm_pkg::coin_t                    total
);

	localparam int RM_W = bccm_pkg::REM_W - 1;

	logic signed [RM_W:0] diff;
	logic [RM_W-1:0]      k2_d, k2_q, rem_q;
	bccm_pkg::coin_t      sum_q;
	logic                 fit;

	always_comb begin
		diff = $signed({1'b0, rem}) - $signed({{(RM_W + 1 - COUNT_BITS){1'b0}}, c1});
		if (diff[RM_W] || diff == '0) begin
			k2_d = '0;
		end else begin
			k2_d = (diff[RM_W-1:0] >> 1) + RM_W'(diff[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.bot1) begin
			k2_q  <= k2_d;
			rem_q <= rem;
			sum_q <= base + bccm_pkg::coin_t'(rem);
		end
	end

	always_comb begin
		fit   = (k2_q <= {{(RM_W - COUNT_BITS){1'b0}}, c2}) && ({k2_q, 1'b0} <= {1'b0, rem_q});
		total = sum_q - bccm_pkg::coin_t'(k2_q);
		upd   = ctl.bot2 && fit && (!found || total > best);
	end

endmodule

`default_nettype wire

@@ src/bounded_coin_change_max_coins.sv @@
// After accept ST_INIT builds the bounds, ST_EVAL visits nodes, ST_ADV returns to a parent
// level, ST_BOT1/ST_BOT2 finish a leaf, ST_DONE latches; then a one-cycle result strobe.
// One transaction at a time; in ST_EVAL the node unit judges one count per cycle, so the run
// time follows the search. Busy stays high from accept until the result strobe; no stalls.
// Asynchronous active-low reset clears the sequencer, the best-so-far flag and the outputs.
// Depends on bccm_pkg, bccm_ctrl, bccm_node, bccm_bottom.
`default_nettype none

module bounded_coin_change_max_coins #(
	parameter int NUM_DENOMINATIONS = 8,
	parameter int COUNT_BITS        = 8
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire [bccm_pkg::PRICE_W-1:0]     price,
	input  wire [COUNT_BITS-1:0]            count_one,
	input  wire [COUNT_BITS-1:0]            count_two,
	input  wire [COUNT_BITS-1:0]            count_five,
	input  wire [COUNT_BITS-1:0]            count_ten,
	input  wire [COUNT_BITS-1:0]            count_twenty,
	input  wire [COUNT_BITS-1:0]            count_fifty,
	input  wire [COUNT_BITS-1:0]            count_hundred,
	input  wire [COUNT_BITS-1:0]            count_twohundred,
	output logic                            done,
	output logic [bccm_pkg::BEST_W-1:0]     best_coins,
	output logic                            impossible
);

	localparam int KW     = COUNT_BITS + 1;
	localparam int CAP_W  = COUNT_BITS + 9;
	localparam int CNTB_W = COUNT_BITS + 3;
	localparam int PROD_W = COUNT_BITS + 8;

	bccm_pkg::ctrl_t      ctl;
	bccm_pkg::node_stat_t stat;

	logic [COUNT_BITS-1:0] cnt_in [bccm_pkg::NUM_DENOM_ALL];
	logic [COUNT_BITS-1:0] cnt_q  [bccm_pkg::NUM_DENOM_ALL];

	logic [KW-1:0]         lvl_k_q  [bccm_pkg::NUM_LEVELS];
	bccm_pkg::coin_t       lvl_ck_q [bccm_pkg::NUM_LEVELS];
	bccm_pkg::rem_t        lvl_rp_q [bccm_pkg::NUM_LEVELS];
	logic [CAP_W-1:0]      cap_q    [bccm_pkg::NUM_LEVELS];
	logic [CNTB_W-1:0]     cntb_q   [bccm_pkg::NUM_LEVELS];

	logic [CAP_W-1:0]      acc_q, acc_d;
	logic [CNTB_W-1:0]     cacc_q, cacc_d;
	logic [PROD_W-1:0]     prod;

	bccm_pkg::lvl_t        cidx, dep_up, cap_idx;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [KW-1:0]         k_cur;
	bccm_pkg::coin_t       ck_cur;
	bccm_pkg::rem_t        rp_cur, v_rem;
	logic [bccm_pkg::DENOM_W-1:0] v_cur, v_idx;

	bccm_pkg::coin_t       best_q, total;
	logic                  found_q, upd;

	logic                  done_q, impossible_q;
	logic [bccm_pkg::BEST_W-1:0] best_coins_q;

	assign cnt_in[0] = count_one;
	assign cnt_in[1] = count_two;
	assign cnt_in[2] = count_five;
	assign cnt_in[3] = count_ten;
	assign cnt_in[4] = count_twenty;
	assign cnt_in[5] = count_fifty;
	assign cnt_in[6] = count_hundred;
	assign cnt_in[7] = count_twohundred;

	bccm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	always_comb begin
		cidx    = ctl.init_acc ? ctl.idx : (bccm_pkg::DENOM_LAST - ctl.depth);
		cnt_cur = cnt_q[cidx];
		dep_up  = ctl.depth + bccm_pkg::lvl_t'(1);
		cap_idx = bccm_pkg::LVL_NUM - ctl.idx;
		k_cur   = lvl_k_q[ctl.depth];
		ck_cur  = lvl_ck_q[ctl.depth];
		rp_cur  = lvl_rp_q[ctl.depth];
		v_cur   = bccm_pkg::denom_value(bccm_pkg::DENOM_LAST - ctl.depth);
		v_rem   = $signed({{(bccm_pkg::REM_W - bccm_pkg::DENOM_W){1'b0}}, v_cur});
		v_idx   = bccm_pkg::denom_value(ctl.idx);
		prod    = {{COUNT_BITS{1'b0}}, v_idx} * {8'd0, cnt_cur};
		acc_d   = acc_q + CAP_W'(prod);
		cacc_d  = cacc_q + CNTB_W'(cnt_cur);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int d = 0; d < bccm_pkg::NUM_DENOM_ALL; d++) begin
				cnt_q[d] <= (d < NUM_DENOMINATIONS) ? cnt_in[d] : '0;
			end
			acc_q  <= '0;
			cacc_q <= '0;
		end else if (ctl.init_acc) begin
			acc_q  <= acc_d;
			cacc_q <= cacc_d;
			if (ctl.idx != '0) begin
				cap_q[cap_idx]  <= acc_d;
				cntb_q[cap_idx] <= cacc_d;
			end
		end
	end

	// level stack: chosen count, coins so far, amount still to pay
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lvl_k_q[0]  <= '0;
			lvl_ck_q[0] <= '0;
			lvl_rp_q[0] <= $signed({{(bccm_pkg::REM_W - bccm_pkg::PRICE_W){1'b0}}, price});
		end else if (ctl.push) begin
			lvl_k_q[dep_up]  <= '0;
			lvl_ck_q[dep_up] <= ck_cur;
			lvl_rp_q[dep_up] <= rp_cur;
		end else if (ctl.adv) begin
			lvl_k_q[ctl.depth]  <= k_cur + KW'(1);
			lvl_ck_q[ctl.depth] <= ck_cur + bccm_pkg::coin_t'(1);
			lvl_rp_q[ctl.depth] <= rp_cur - v_rem;
		end
	end

	bccm_node #(
		.COUNT_BITS (COUNT_BITS)
	) u_node (
		.k     (k_cur),
		.ck    (ck_cur),
		.rp    (rp_cur),
		.cnt   (cnt_cur),
		.cap   (cap_q[ctl.depth]),
		.cntb  (cntb_q[ctl.depth]),
		.best  (best_q),
		.found (found_q),
		.stat  (stat)
	);

	bccm_bottom #(
		.COUNT_BITS (COUNT_BITS)
	) u_bottom (
		.clk   (clk),
		.ctl   (ctl),
		.rem   (rp_cur[bccm_pkg::REM_W-2:0]),
		.base  (ck_cur),
		.c1    (cnt_q[0]),
		.c2    (cnt_q[1]),
		.best  (best_q),
		.found (found_q),
		.upd   (upd),
		.total (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_q  <= '0;
		end else if (ctl.load) begin
			found_q <= 1'b0;
		end else if (upd) begin
			found_q <= 1'b1;
			best_q  <= total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= 1'b0;
			best_coins_q <= '0;
			impossible_q <= 1'b0;
		end else begin
			done_q <= ctl.done;
			if (ctl.done) begin
				impossible_q <= !found_q;
				if (!found_q) begin
					best_coins_q <= '0;
				end else if (best_q > bccm_pkg::coin_t'(bccm_pkg::BEST_MAX)) begin
					best_coins_q <= bccm_pkg::BEST_MAX;
				end else begin
					best_coins_q <= best_q[bccm_pkg::BEST_W-1:0];
				end
			end
		end
	end

	assign done       = done_q;
	assign best_coins = best_coins_q;
	assign impossible = impossible_q;

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_imp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && impossible) |-> (best_coins == '0))
		else $error("impossible result with nonzero coin count");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (ctl.depth <= bccm_pkg::LVL_LAST))
		else $error("search depth out of range");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction accepted but block not busy");
`endif

endmodule

`default_nettype wire

@@ dv/tb_bounded_coin_change_max_coins.sv @@
// Self-checking testbench for bounded_coin_change_max_coins: directed table then random orders,
// each result checked against a hand-entered value or a bounded-knapsack predictor of the most coins.
// Depends on bccm_pkg and the bounded_coin_change_max_coins RTL.
`default_nettype none

module tb_bounded_coin_change_max_coins;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CNT_W        = 8;
	localparam int     N_RANDOM     = 450;
	localparam int     SETTLE_CYC   = 40;
	localparam longint LIMIT_CYCLES = 64'd8000000;
	// face values, index 0 = one unit coin
	localparam logic [7:0][7:0] FACE = {8'd200, 8'd100, 8'd50, 8'd20, 8'd10, 8'd5, 8'd2, 8'd1};

	typedef struct packed {
		logic [bccm_pkg::PRICE_W-1:0] price;
		logic [7:0][CNT_W-1:0]        cnt;
	} order_t;

	typedef struct packed {
		logic [bccm_pkg::BEST_W-1:0] best;
		logic                        imp;
	} payout_t;

	typedef struct {
		order_t  o;
		bit      typed;
		payout_t want;
	} row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [bccm_pkg::PRICE_W-1:0]  price;
	logic [CNT_W-1:0]              count_one;
	logic [CNT_W-1:0]              count_two;
	logic [CNT_W-1:0]              count_five;
	logic [CNT_W-1:0]              count_ten;
	logic [CNT_W-1:0]              count_twenty;
	logic [CNT_W-1:0]              count_fifty;
	logic [CNT_W-1:0]              count_hundred;
	logic [CNT_W-1:0]              count_twohundred;
	logic                          done;
	logic [bccm_pkg::BEST_W-1:0]   best_coins;
	logic                          impossible;

	payout_t pending_payouts [$];
	row_t    directed_rows [$];
	int      mismatches;
	int      n_sent;
	int      n_typed;
	int      n_results;
	int      n_impossible;
	int      top_best;
	int      burst_left;
	longint  cycles;

	bounded_coin_change_max_coins #(
		.NUM_DENOMINATIONS(8),
		.COUNT_BITS(CNT_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.price(price),
		.count_one(count_one),
		.count_two(count_two),
		.count_five(count_five),
		.count_ten(count_ten),
		.count_twenty(count_twenty),
		.count_fifty(count_fifty),
		.count_hundred(count_hundred),
		.count_twohundred(count_twohundred),
		.done(done),
		.best_coins(best_coins),
		.impossible(impossible)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// bounded knapsack, maximizing coin count, counts split in powers of two
	function automatic payout_t most_coins_for(order_t o);
		payout_t r;
		int target;
		int reach;
		int left;
		int chunk;
		int take;
		int w;
		int a;
		int d;
		int tbl [];
		target = int'(o.price);
		reach = 0;
		for (d = 0; d < 8; d++)
			reach += int'(FACE[d]) * int'(o.cnt[d]);
		r.best = '0;
		r.imp = 1'b1;
		if (target > reach)
			return r;
		tbl = new[target + 1];
		tbl[0] = 0;
		for (a = 1; a <= target; a++)
			tbl[a] = -1;
		for (d = 0; d < 8; d++) begin
			left = int'(o.cnt[d]);
			chunk = 1;
			while (left > 0) begin
				take = (chunk < left) ? chunk : left;
				w = take * int'(FACE[d]);
				for (a = target; a >= w; a--)
					if (tbl[a - w] >= 0 && tbl[a - w] + take > tbl[a])
						tbl[a] = tbl[a - w] + take;
				left -= take;
				chunk *= 2;
			end
		end
		if (tbl[target] >= 0) begin
			r.imp = 1'b0;
			r.best = (tbl[target] > int'(bccm_pkg::BEST_MAX)) ? bccm_pkg::BEST_MAX :
				bccm_pkg::BEST_W'(tbl[target]);
		end
		return r;
	endfunction

	function automatic order_t random_order();
		order_t o;
		int mode;
		int big;
		int d;
		int unsigned amt;
		mode = $urandom_range(0, 99);
		for (d = 2; d < 8; d++)
			o.cnt[d] = ($urandom_range(0, 4) == 0) ? '0 : CNT_W'($urandom_range(0, 2));
		if (mode < 4) begin
			for (d = 2; d < 8; d++)
				o.cnt[d] = CNT_W'($urandom_range(0, 1));
			big = $urandom_range(2, 7);
			o.cnt[big] = CNT_W'($urandom_range(128, 255));
		end
		for (d = 0; d < 2; d++)
			o.cnt[d] = $urandom_range(0, 1) ? CNT_W'($urandom_range(0, 255)) :
				CNT_W'($urandom_range(0, 7));
		if (mode < 70) begin
			// payable: sum of a random subset of the coins on hand
			amt = 0;
			for (d = 0; d < 8; d++)
				amt += FACE[d] * $urandom_range(0, o.cnt[d]);
			o.price = amt[bccm_pkg::PRICE_W-1:0];
		end else if (mode < 85) begin
			o.price = bccm_pkg::PRICE_W'($urandom_range(0, 600));
		end else begin
			o.price = bccm_pkg::PRICE_W'($urandom_range(0, 65535));
		end
		return o;
	endfunction

	task automatic put_fields(order_t o);
		price <= o.price;
		count_one <= o.cnt[0];
		count_two <= o.cnt[1];
		count_five <= o.cnt[2];
		count_ten <= o.cnt[3];
		count_twenty <= o.cnt[4];
		count_fifty <= o.cnt[5];
		count_hundred <= o.cnt[6];
		count_twohundred <= o.cnt[7];
	endtask

	task automatic add_row(int p, int c1, int c2, int c5, int c10, int c20, int c50, int c100,
			int c200, bit typed, int best, bit imp);
		row_t r;
		r.o.price = bccm_pkg::PRICE_W'(p);
		r.o.cnt = {CNT_W'(c200), CNT_W'(c100), CNT_W'(c50), CNT_W'(c20), CNT_W'(c10),
			CNT_W'(c5), CNT_W'(c2), CNT_W'(c1)};
		r.typed = typed;
		r.want.best = bccm_pkg::BEST_W'(best);
		r.want.imp = imp;
		directed_rows.push_back(r);
	endtask

	task automatic send_order(order_t o, payout_t want);
		start <= 1'b1;
		put_fields(o);
		do @(posedge clk); while (busy);
		pending_payouts.push_back(want);
		n_sent++;
	endtask

	// burst / gap pacing; idle fields carry noise
	task automatic pace();
		int gap;
		order_t junk;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 10);
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 800) : $urandom_range(1, 20);
		repeat (gap) begin
			junk.price = bccm_pkg::PRICE_W'($urandom);
			junk.cnt = {$urandom, $urandom};
			start <= 1'b0;
			put_fields(junk);
			@(posedge clk);
		end
	endtask

	// drop start so the last transaction is not taken again once busy falls
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_payouts.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		payout_t e;
		if (arst_n && done) begin
			n_results++;
			if (impossible)
				n_impossible++;
			if (int'(best_coins) > top_best)
				top_best = int'(best_coins);
			if (pending_payouts.size() == 0) begin
				report_mismatch($sformatf("result best_coins=%0d impossible=%0b with none outstanding",
					best_coins, impossible));
			end else begin
				e = pending_payouts.pop_front();
				if (best_coins !== e.best)
					report_mismatch($sformatf("best_coins got %0d want %0d", best_coins, e.best));
				if (impossible !== e.imp)
					report_mismatch($sformatf("impossible got %0b want %0b", impossible, e.imp));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_payouts.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		order_t o;
		int i;
		mismatches = 0;
		n_sent = 0;
		n_typed = 0;
		n_results = 0;
		n_impossible = 0;
		top_best = 0;
		burst_left = 0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		price = '0;
		count_one = '0;
		count_two = '0;
		count_five = '0;
		count_ten = '0;
		count_twenty = '0;
		count_fifty = '0;
		count_hundred = '0;
		count_twohundred = '0;

		//      price  1    2    5    10   20   50   100  200  typed best imp
		add_row(0,     0,   0,   0,   0,   0,   0,   0,   0,   1, 0,   0);
		add_row(0,     255, 255, 255, 255, 255, 255, 255, 255, 1, 0,   0);
		add_row(65535, 0,   0,   0,   0,   0,   0,   0,   0,   1, 0,   1);
		add_row(65535, 1,   1,   1,   1,   1,   1,   1,   1,   1, 0,   1);
		add_row(1,     0,   0,   0,   0,   0,   0,   0,   0,   1, 0,   1);
		add_row(3,     0,   1,   0,   0,   0,   0,   0,   0,   1, 0,   1);
		add_row(255,   255, 0,   0,   0,   0,   0,   0,   0,   1, 255, 0);
		add_row(510,   0,   255, 0,   0,   0,   0,   0,   0,   1, 255, 0);
		add_row(1275,  0,   0,   255, 0,   0,   0,   0,   0,   1, 255, 0);
		add_row(2550,  0,   0,   0,   255, 0,   0,   0,   0,   1, 255, 0);
		add_row(5100,  0,   0,   0,   0,   255, 0,   0,   0,   1, 255, 0);
		add_row(12750, 0,   0,   0,   0,   0,   255, 0,   0,   1, 255, 0);
		add_row(25500, 0,   0,   0,   0,   0,   0,   255, 0,   1, 255, 0);
		add_row(51000, 0,   0,   0,   0,   0,   0,   0,   255, 1, 255, 0);
		add_row(6,     1,   1,   1,   0,   0,   0,   0,   0,   0, 0,   0);
		add_row(400,   0,   0,   0,   0,   0,   0,   4,   2,   0, 0,   0);
		add_row(30,    0,   0,   2,   3,   1,   0,   0,   0,   0, 0,   0);
		add_row(388,   1,   1,   1,   1,   1,   1,   1,   1,   0, 0,   0);
		add_row(387,   1,   1,   1,   1,   1,   1,   1,   1,   0, 0,   0);
		add_row(9,     4,   2,   1,   0,   0,   0,   0,   0,   0, 0,   0);
		add_row(7,     255, 255, 255, 255, 255, 255, 255, 255, 0, 0,   0);
		add_row(300,   255, 255, 0,   0,   0,   0,   0,   0,   0, 0,   0);
		add_row(123,   3,   2,   2,   2,   2,   1,   1,   1,   0, 0,   0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].typed)
				n_typed++;
			send_order(directed_rows[k].o,
				directed_rows[k].typed ? directed_rows[k].want : most_coins_for(directed_rows[k].o));
			pace();
		end
		wait_drained();

		for (i = 0; i < N_RANDOM; i++) begin
			o = random_order();
			send_order(o, most_coins_for(o));
			if (i == N_RANDOM / 2)
				wait_drained();
			else
				pace();
		end
		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);

		$display("covered %0d transactions (%0d with hand-entered results), %0d results seen",
			n_sent, n_typed, n_results);
		$display("%0d had no exact payment, largest coin count %0d, %0d cycles, %0d mismatches",
			n_impossible, top_best, cycles, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
src/bccm_pkg.sv
src/bccm_ctrl.sv
src/bccm_node.sv
src/bccm_bottom.sv
src/bounded_coin_change_max_coins.sv
dv/tb_bounded_coin_change_max_coins.sv
